// ===== hdl/a2fe_pkg.sv =====
package a2fe_pkg;

  // Default number of fraction bits of an incoming gene
  localparam int GENE_FRAC_BITS = 12;

  // Fixed-point constants
  localparam logic [31:0] ONE_Q16        = 32'h0001_0000;
  localparam logic [33:0] TEN_Q16        = 34'd655360;
  localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

  // First probe bit of the digit-by-digit square root
  localparam logic [47:0] SQRT_BIT0 = 48'h4000_0000_0000;

  // Horner divisors of the sine polynomial, with floor(2^33 / d) reciprocals
  localparam int DIV_CNT = 5;
  localparam int IDX_W   = $clog2(DIV_CNT);

  // Normalization: (v + 10) / 20 via floor(2^36 / 20)
  localparam logic [31:0] NORM_RECIP = 32'd3435973836;
  localparam logic [4:0]  NORM_DIV   = 5'd20;
  localparam logic [4:0]  NORM_BIAS  = 5'd10;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_PHASE,
    OP_ANGLE,
    OP_RSQ,
    OP_R2,
    OP_TMUL,
    OP_RECIP,
    OP_CORR,
    OP_SMUL,
    OP_SIN,
    OP_TERM,
    OP_TM,
    OP_PROD,
    OP_UPDATE,
    OP_NORM_A,
    OP_NORM_B,
    OP_NORM_C
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_last;
    logic last_gene;
    logic out_free;
  } dp_stat_t;

  // Divisor of Horner step i: 110, 72, 42, 20, 6
  function automatic logic [6:0] div_const(input logic [IDX_W-1:0] i);
    logic [6:0] d;
    case (i)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      3'd4:    d = 7'd6;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^33 / divisor) of Horner step i
  function automatic logic [31:0] recip_const(input logic [IDX_W-1:0] i);
    logic [31:0] m;
    case (i)
      3'd0:    m = 32'd78090314;
      3'd1:    m = 32'd119304647;
      3'd2:    m = 32'd204522252;
      3'd3:    m = 32'd429496729;
      3'd4:    m = 32'd1431655765;
      default: m = 32'd1431655765;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/a2fe_ctrl.sv =====
module a2fe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output a2fe_pkg::dp_cmd_t  cmd,
  input  a2fe_pkg::dp_stat_t stat
);

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_PHASE  = 17'h00002,
    ST_ANGLE  = 17'h00004,
    ST_RSQ    = 17'h00008,
    ST_R2     = 17'h00010,
    ST_TMUL   = 17'h00020,
    ST_RECIP  = 17'h00040,
    ST_CORR   = 17'h00080,
    ST_SMUL   = 17'h00100,
    ST_SIN    = 17'h00200,
    ST_TERM   = 17'h00400,
    ST_TM     = 17'h00800,
    ST_PROD   = 17'h01000,
    ST_UPDATE = 17'h02000,
    ST_NORM_A = 17'h04000,
    ST_NORM_B = 17'h08000,
    ST_NORM_C = 17'h10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a new item only between genes
  assign in_stall = (state_r != ST_IDLE);

  // Sequence the datapath one operation per cycle, but for the holds on the square root and the output register
  always_comb begin
    state_nxt = state_r;
    cmd.op    = a2fe_pkg::OP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = a2fe_pkg::OP_LOAD;
          state_nxt = ST_PHASE;
        end
      end
      ST_PHASE: begin
        cmd.op    = a2fe_pkg::OP_PHASE;
        state_nxt = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd.op    = a2fe_pkg::OP_ANGLE;
        state_nxt = ST_RSQ;
      end
      ST_RSQ: begin
        cmd.op    = a2fe_pkg::OP_RSQ;
        state_nxt = ST_R2;
      end
      ST_R2: begin
        cmd.op    = a2fe_pkg::OP_R2;
        state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        cmd.op    = a2fe_pkg::OP_TMUL;
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        cmd.op    = a2fe_pkg::OP_RECIP;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        cmd.op    = a2fe_pkg::OP_CORR;
        state_nxt = stat.div_last ? ST_SMUL : ST_TMUL;
      end
      ST_SMUL: begin
        cmd.op    = a2fe_pkg::OP_SMUL;
        state_nxt = ST_SIN;
      end
      ST_SIN: begin
        cmd.op    = a2fe_pkg::OP_SIN;
        state_nxt = ST_TERM;
      end
      // Hold until the square root has settled
      ST_TERM: begin
        if (stat.sqrt_done) begin
          cmd.op    = a2fe_pkg::OP_TERM;
          state_nxt = ST_TM;
        end
      end
      ST_TM: begin
        cmd.op    = a2fe_pkg::OP_TM;
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.op    = a2fe_pkg::OP_PROD;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.op    = a2fe_pkg::OP_UPDATE;
        state_nxt = stat.last_gene ? ST_NORM_A : ST_IDLE;
      end
      ST_NORM_A: begin
        cmd.op    = a2fe_pkg::OP_NORM_A;
        state_nxt = ST_NORM_B;
      end
      ST_NORM_B: begin
        cmd.op    = a2fe_pkg::OP_NORM_B;
        state_nxt = ST_NORM_C;
      end
      // Hold until the output register can take the result
      ST_NORM_C: begin
        if (stat.out_free) begin
          cmd.op    = a2fe_pkg::OP_NORM_C;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/a2fe_dp.sv =====
module a2fe_dp #(
  parameter int GENE_FRAC_BITS = a2fe_pkg::GENE_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  a2fe_pkg::dp_cmd_t   cmd,
  output a2fe_pkg::dp_stat_t  stat,
  input  logic [15:0]         in_gene,
  input  logic                in_last_gene,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_func_value,
  output logic signed [31:0]  out_norm_fitness,
  output logic                out_saturated
);

  localparam int ShiftL = (GENE_FRAC_BITS <= 16) ? 16 - GENE_FRAC_BITS : 0;
  localparam int ShiftR = (GENE_FRAC_BITS > 16) ? GENE_FRAC_BITS - 16 : 0;

  // Gene and square root state
  logic [31:0] x_r;
  logic        last_r;
  logic [47:0] n_r;
  logic [47:0] res_r;
  logic [47:0] bit_r;

  // Shared multiplier and sine state
  logic [63:0] mul_r;
  logic [1:0]  quad_r;
  logic [30:0] r_r;
  logic [31:0] r2_r;
  logic [30:0] t_r;
  logic [31:0] p_r;
  logic [a2fe_pkg::IDX_W-1:0] idx_r;
  logic [17:0] sm_r;
  logic        sneg_r;

  // Product and normalization state
  logic [24:0] tm_r;
  logic [31:0] pm_r;
  logic        pneg_r;
  logic [31:0] prod_r;
  logic        sat_r;
  logic [31:0] vm_r;
  logic        vneg_r;

  // Output register
  logic        out_valid_r;
  logic [31:0] out_func_r;
  logic [31:0] out_norm_r;
  logic        out_sat_r;

  logic [31:0] gene_q16;
  logic [47:0] sq_sum;
  logic        sq_ge;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_nxt;
  logic        mul_en;

  logic [29:0] f_raw;
  logic [30:0] f_fold;
  logic [30:0] r_w;
  logic [31:0] r2_w;
  logic [29:0] q_est;
  logic [6:0]  div_w;
  logic [36:0] qd;
  logic [32:0] corr_rem;
  logic [30:0] corr_q;
  logic [31:0] sin_round;
  logic [40:0] tm_round;
  logic [57:0] upd_round;
  logic [41:0] upd_m;
  logic        upd_neg;
  logic [31:0] prod_nxt;
  logic        sat_nxt;
  logic [33:0] norm_v;
  logic [33:0] norm_vm;
  logic [27:0] nq_est;
  logic [32:0] nqd;
  logic [32:0] nrem;
  logic [31:0] nq;
  logic [31:0] nf;

  // Align the gene to Q16.16
  assign gene_q16 = (32'(in_gene) << ShiftL) >> ShiftR;

  // Square root: one result bit per cycle, runs beside the sine sequence
  assign sq_sum = res_r + bit_r;
  assign sq_ge  = (n_r >= sq_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (cmd.op == a2fe_pkg::OP_LOAD) begin
      bit_r <= a2fe_pkg::SQRT_BIT0;
    end else if (bit_r != '0) begin
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == a2fe_pkg::OP_LOAD) begin
      n_r   <= {gene_q16, 16'h0000};
      res_r <= '0;
    end else if (bit_r != '0) begin
      if (sq_ge) begin
        n_r   <= n_r - sq_sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end

  // Fields taken from the last product
  assign f_raw  = mul_r[45:16];
  assign f_fold = mul_r[46] ? (a2fe_pkg::ONE_Q30 - {1'b0, f_raw}) : {1'b0, f_raw};
  assign r_w    = mul_r[60:30];
  assign r2_w   = mul_r[61:30];
  assign q_est  = mul_r[62:33];
  assign nq_est = mul_r[63:36];

  // Select the multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      a2fe_pkg::OP_PHASE: begin
        mul_a = x_r;
        mul_b = a2fe_pkg::INV_TWO_PI_Q32;
      end
      a2fe_pkg::OP_ANGLE: begin
        mul_a = 32'(f_fold);
        mul_b = 32'(a2fe_pkg::HALF_PI_Q30);
      end
      a2fe_pkg::OP_RSQ: begin
        mul_a = 32'(r_w);
        mul_b = 32'(r_w);
      end
      a2fe_pkg::OP_TMUL: begin
        mul_a = r2_r;
        mul_b = 32'(t_r);
      end
      a2fe_pkg::OP_RECIP: begin
        mul_a = r2_w;
        mul_b = a2fe_pkg::recip_const(idx_r);
      end
      a2fe_pkg::OP_SMUL: begin
        mul_a = 32'(r_r);
        mul_b = 32'(t_r);
      end
      a2fe_pkg::OP_TERM: begin
        mul_a = 32'(res_r[20:0]);
        mul_b = 32'(sm_r);
      end
      a2fe_pkg::OP_PROD: begin
        mul_a = pm_r;
        mul_b = 32'(tm_r);
      end
      a2fe_pkg::OP_NORM_B: begin
        mul_a = vm_r;
        mul_b = a2fe_pkg::NORM_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_nxt = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    case (cmd.op) inside
      a2fe_pkg::OP_PHASE, a2fe_pkg::OP_ANGLE, a2fe_pkg::OP_RSQ, a2fe_pkg::OP_TMUL,
      a2fe_pkg::OP_RECIP, a2fe_pkg::OP_SMUL, a2fe_pkg::OP_TERM, a2fe_pkg::OP_PROD,
      a2fe_pkg::OP_NORM_B: mul_en = 1'b1;
      default:             mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_r <= mul_nxt;
    end
  end

  // Horner step: exact quotient by a constant from the reciprocal estimate
  assign div_w    = a2fe_pkg::div_const(idx_r);
  assign qd       = 37'(q_est) * 37'(div_w);
  assign corr_rem = {1'b0, p_r} - qd[32:0];
  assign corr_q   = {1'b0, q_est} + 31'(corr_rem >= 33'(div_w));

  // Round the sine to Q2.16 and the term to Q9.16
  assign sin_round = 32'(r_w) + 32'h0000_2000;
  assign tm_round  = {1'b0, mul_r[39:0]} + 41'h0_0000_8000;

  // Round, sign and clamp the new running product
  assign upd_round = mul_r[57:0] + 58'h800_0;
  assign upd_m     = upd_round[57:16];
  assign upd_neg   = (pneg_r != sneg_r) && (upd_m != '0);

  always_comb begin
    prod_nxt = prod_r;
    sat_nxt  = sat_r;
    if (!upd_neg) begin
      if (upd_m > 42'h0_7FFF_FFFF) begin
        prod_nxt = 32'h7FFF_FFFF;
        sat_nxt  = 1'b1;
      end else begin
        prod_nxt = upd_m[31:0];
      end
    end else begin
      if (upd_m > 42'h0_8000_0000) begin
        prod_nxt = 32'h8000_0000;
        sat_nxt  = 1'b1;
      end else begin
        prod_nxt = 32'h0 - upd_m[31:0];
      end
    end
  end

  // Normalization: magnitude of (product + 10), rounded quotient by 20, then the sign put back
  assign norm_v  = {{2{prod_r[31]}}, prod_r} + a2fe_pkg::TEN_Q16;
  assign norm_vm = norm_v[33] ? (34'h0 - norm_v) : norm_v;
  assign nqd     = 33'(nq_est) * 33'(a2fe_pkg::NORM_DIV);
  assign nrem    = {1'b0, vm_r} - nqd;
  assign nq      = 32'(nq_est) + 32'(nrem >= 33'(a2fe_pkg::NORM_DIV));
  assign nf      = vneg_r ? (32'h0 - nq) : nq;

  // Payload registers of the load, sine, product and normalization steps
  always_ff @(posedge clk) begin
    case (cmd.op)
      a2fe_pkg::OP_LOAD: begin
        x_r    <= gene_q16;
        last_r <= in_last_gene;
      end
      a2fe_pkg::OP_ANGLE: begin
        quad_r <= mul_r[47:46];
      end
      a2fe_pkg::OP_RSQ: begin
        r_r <= r_w;
      end
      a2fe_pkg::OP_R2: begin
        r2_r  <= r2_w;
        t_r   <= a2fe_pkg::ONE_Q30;
        idx_r <= '0;
      end
      a2fe_pkg::OP_RECIP: begin
        p_r <= r2_w;
      end
      a2fe_pkg::OP_CORR: begin
        t_r   <= a2fe_pkg::ONE_Q30 - corr_q;
        idx_r <= idx_r + a2fe_pkg::IDX_W'(1);
      end
      a2fe_pkg::OP_SIN: begin
        sm_r   <= sin_round[31:14];
        sneg_r <= quad_r[1];
      end
      a2fe_pkg::OP_TM: begin
        tm_r   <= tm_round[40:16];
        pm_r   <= prod_r[31] ? (32'h0 - prod_r) : prod_r;
        pneg_r <= prod_r[31];
      end
      a2fe_pkg::OP_NORM_A: begin
        vm_r   <= norm_vm[31:0] + 32'(a2fe_pkg::NORM_BIAS);
        vneg_r <= norm_v[33];
      end
      default: begin
      end
    endcase
  end

  // Running product and clip flag; restart after the last gene
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= a2fe_pkg::ONE_Q16;
      sat_r  <= 1'b0;
    end else if (cmd.op == a2fe_pkg::OP_UPDATE) begin
      prod_r <= prod_nxt;
      sat_r  <= sat_nxt;
    end else if (cmd.op == a2fe_pkg::OP_NORM_C) begin
      prod_r <= a2fe_pkg::ONE_Q16;
      sat_r  <= 1'b0;
    end
  end

  // Output register: load the result item, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == a2fe_pkg::OP_NORM_C) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == a2fe_pkg::OP_NORM_C) begin
      out_func_r <= prod_r;
      out_norm_r <= nf;
      out_sat_r  <= sat_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_func_value   = $signed(out_func_r);
  assign out_norm_fitness = $signed(out_norm_r);
  assign out_saturated    = out_sat_r;

  // Status back to the controller
  assign stat.sqrt_done = (bit_r == '0);
  assign stat.div_last  = (idx_r == a2fe_pkg::IDX_W'(a2fe_pkg::DIV_CNT - 1));
  assign stat.last_gene = last_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

// ===== hdl/alpine2_fitness_evaluator_top.sv =====
// Alpine2 fitness evaluator: running product of sqrt(gene)*sin(gene), one gene per item.
// Genes are taken one at a time: a new gene is accepted only after the last one has updated
// the running product; the 24-step square root, run beside the shared-multiplier sine sequence,
// sets this pace. The result item is loaded into the output register after normalization.
// Reset (rst_n, synchronous, active low): idle, running product 1.0, clip flag clear,
// no result item pending.
module alpine2_fitness_evaluator_top #(
  parameter int GENE_FRAC_BITS = a2fe_pkg::GENE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_gene,
  input  logic               in_last_gene,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_func_value,
  output logic signed [31:0] out_norm_fitness,
  output logic               out_saturated
);

  a2fe_pkg::dp_cmd_t  cmd;
  a2fe_pkg::dp_stat_t stat;

  // Sequencer
  a2fe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Arithmetic and result register
  a2fe_dp #(
    .GENE_FRAC_BITS (GENE_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_gene          (in_gene),
    .in_last_gene     (in_last_gene),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_func_value   (out_func_value),
    .out_norm_fitness (out_norm_fitness),
    .out_saturated    (out_saturated)
  );

endmodule
